>>> hw/rtl/ptp_pkg.sv
// ----------------------------------------------------------------------------
// ptp_pkg
// shared types and codes of the priority table with promote
// ----------------------------------------------------------------------------
package ptp_pkg;

    // command codes
    localparam logic [2:0] KIND_ADD     = 3'd0;
    localparam logic [2:0] KIND_PROMOTE = 3'd1;
    localparam logic [2:0] KIND_PEEK    = 3'd2;
    localparam logic [2:0] KIND_POP     = 3'd3;
    localparam logic [2:0] KIND_QUERY   = 3'd4;

    // response status codes
    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_FULL   = 2'd1;
    localparam logic [1:0] STATUS_EMPTY  = 2'd2;
    localparam logic [1:0] STATUS_BAD_ID = 2'd3;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  entry_id;
        logic [31:0] payload_in;
    } ptp_cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  result_id;
        logic [31:0] payload_out;
        logic [15:0] priority_out;
        logic        is_live;
    } ptp_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_APPLY,
        ST_SCAN,
        ST_RETIRE,
        ST_DONE
    } ptp_state_t;

endpackage

>>> hw/rtl/ptp_ram.sv
// ----------------------------------------------------------------------------
// ptp_ram
// single write port, single read port table storage with registered read
// ----------------------------------------------------------------------------
module ptp_ram
#(
    parameter int DEPTH = 256,
    parameter int WIDTH = 49,
    localparam int AW = $clog2(DEPTH)
)(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/priority_table_with_promote_top.sv
// ----------------------------------------------------------------------------
// priority_table_with_promote_top
// indexed max-priority table with add, promote, peek, pop and query
// ----------------------------------------------------------------------------
// One command transaction is taken at a time and answered by exactly one
// response transaction. Peek and pop scan the table, and pop then adds a
// retire write: every issued id is read in turn through the single read
// port of the entry memory and checked by one priority comparator. A
// response still held by rsp_stall adds its wait to the next command. Ids
// are handed out in order from 0 and never reused, so an id is issued
// exactly when it is below the issued count, and an issued entry is live
// until pop retires it; each memory word carries a retired flag that add
// clears and pop sets, which needs no clearing pass after reset. The
// response sits in its own output register, so a new command is taken
// while the previous response still waits on rsp_stall.
// ----------------------------------------------------------------------------
module priority_table_with_promote_top
    import ptp_pkg::*;
#(
    parameter int CAPACITY       = 256,
    parameter int PAYLOAD_WIDTH  = 32,
    parameter int PRIORITY_WIDTH = 16
)(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_stall,
    input  ptp_cmd_t cmd,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output ptp_rsp_t rsp
);

    // index width, count width (count reaches CAPACITY itself)
    localparam int IW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > 8) ? CW : 8;
    // memory word: {retired, priority, payload}
    localparam int MW       = 1 + PRIORITY_WIDTH + PAYLOAD_WIDTH;
    localparam int DEAD_BIT = MW - 1;
    localparam logic [PRIORITY_WIDTH-1:0] PRIO_TOP = '1;

    // sequencer and control state
    ptp_state_t         state_reg, state_next;
    logic [CW-1:0]      issued_reg, issued_next;
    logic [CW-1:0]      scan_reg, scan_next;
    logic               rd_pend_reg, rd_pend_next;
    logic               found_reg, found_next;
    logic               rsp_valid_reg, rsp_valid_next;

    // captured command and scan datapath
    logic [2:0]                kind_reg, kind_next;
    logic [7:0]                id_reg, id_next;
    logic [PAYLOAD_WIDTH-1:0]  pay_reg, pay_next;
    logic [IW-1:0]             rd_idx_reg, rd_idx_next;
    logic [IW-1:0]             best_idx_reg, best_idx_next;
    logic [PRIORITY_WIDTH-1:0] best_prio_reg, best_prio_next;
    logic [PAYLOAD_WIDTH-1:0]  best_pay_reg, best_pay_next;
    ptp_rsp_t                  res_reg, res_next;
    ptp_rsp_t                  rsp_reg, rsp_next;

    // memory port
    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [MW-1:0] ram_wdata;
    logic          ram_re;
    logic [IW-1:0] ram_raddr;
    logic [MW-1:0] ram_rdata;

    // decoded read word and widened views for the fixed-width response
    logic                      rd_dead;
    logic [PRIORITY_WIDTH-1:0] rd_prio;
    logic [PRIORITY_WIDTH-1:0] prio_inc;
    logic [PAYLOAD_WIDTH-1:0]  rd_pay;
    logic [63:0]               cmd_pay_w;
    logic [63:0]               rd_pay_w;
    logic [63:0]               best_pay_w;
    logic [31:0]               rd_prio_w;
    logic [31:0]               best_prio_w;

    logic table_full;
    logic id_issued;
    logic scan_more;
    logic scan_end;
    logic rsp_free;

    ptp_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (MW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_dead  = ram_rdata[DEAD_BIT];
    assign rd_prio  = ram_rdata[PAYLOAD_WIDTH +: PRIORITY_WIDTH];
    assign rd_pay   = ram_rdata[PAYLOAD_WIDTH-1:0];
    assign prio_inc = rd_prio + PRIORITY_WIDTH'(1);

    // zero-extend / truncate between parameter widths and port widths
    always_comb
    begin
        cmd_pay_w   = 64'(cmd.payload_in);
        rd_pay_w    = '0;
        rd_pay_w[PAYLOAD_WIDTH-1:0] = rd_pay;
        best_pay_w  = '0;
        best_pay_w[PAYLOAD_WIDTH-1:0] = best_pay_reg;
        rd_prio_w   = '0;
        rd_prio_w[PRIORITY_WIDTH-1:0] = rd_prio;
        best_prio_w = '0;
        best_prio_w[PRIORITY_WIDTH-1:0] = best_prio_reg;
    end

    assign table_full = (issued_reg == CW'(CAPACITY));
    // an id below the issued count was written by add at some point
    assign id_issued  = (CMPW'(id_reg) < CMPW'(issued_reg));
    assign scan_more  = (scan_reg < issued_reg);
    // last read word has been compared
    assign scan_end   = !scan_more && !rd_pend_reg;
    assign rsp_free   = !rsp_valid_reg || !rsp_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (kind_reg)
                    KIND_PROMOTE, KIND_QUERY:
                    begin
                        state_next = id_issued ? ST_APPLY : ST_DONE;
                    end
                    KIND_PEEK, KIND_POP:
                    begin
                        state_next = ST_SCAN;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_APPLY:
            begin
                state_next = ST_DONE;
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = (found_reg && kind_reg == KIND_POP) ? ST_RETIRE : ST_DONE;
                end
            end
            ST_RETIRE:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        issued_next    = issued_reg;
        scan_next      = scan_reg;
        rd_pend_next   = rd_pend_reg;
        found_next     = found_reg;
        rsp_valid_next = rsp_valid_reg;
        kind_next      = kind_reg;
        id_next        = id_reg;
        pay_next       = pay_reg;
        rd_idx_next    = rd_idx_reg;
        best_idx_next  = best_idx_reg;
        best_prio_next = best_prio_reg;
        best_pay_next  = best_pay_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = '0;

        // response taken downstream
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    kind_next = cmd.kind;
                    id_next   = cmd.entry_id;
                    pay_next  = cmd_pay_w[PAYLOAD_WIDTH-1:0];
                end
            end
            ST_DISPATCH:
            begin
                res_next = '0;
                case (kind_reg)
                    KIND_ADD:
                    begin
                        if (table_full)
                        begin
                            res_next.status = STATUS_FULL;
                        end
                        else
                        begin
                            // new entry: live, priority zero
                            ram_we             = 1'b1;
                            ram_waddr          = IW'(issued_reg);
                            ram_wdata          = {1'b0, {PRIORITY_WIDTH{1'b0}}, pay_reg};
                            res_next.result_id = 8'(issued_reg);
                            issued_next        = issued_reg + CW'(1);
                        end
                    end
                    KIND_PROMOTE:
                    begin
                        if (id_issued)
                        begin
                            ram_re    = 1'b1;
                            ram_raddr = IW'(id_reg);
                        end
                        else
                        begin
                            res_next.status = STATUS_BAD_ID;
                        end
                    end
                    KIND_QUERY:
                    begin
                        res_next.result_id = id_reg;
                        if (id_issued)
                        begin
                            ram_re    = 1'b1;
                            ram_raddr = IW'(id_reg);
                        end
                    end
                    KIND_PEEK, KIND_POP:
                    begin
                        scan_next    = '0;
                        rd_pend_next = 1'b0;
                        found_next   = 1'b0;
                    end
                    default:
                    begin
                        res_next = '0;
                    end
                endcase
            end
            ST_APPLY:
            begin
                if (kind_reg == KIND_PROMOTE)
                begin
                    if (rd_dead)
                    begin
                        res_next.status = STATUS_BAD_ID;
                    end
                    else if (rd_prio != PRIO_TOP)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = IW'(id_reg);
                        ram_wdata = {1'b0, prio_inc, rd_pay};
                    end
                end
                else if (!rd_dead)
                begin
                    res_next.is_live      = 1'b1;
                    res_next.payload_out  = rd_pay_w[31:0];
                    res_next.priority_out = rd_prio_w[15:0];
                end
            end
            ST_SCAN:
            begin
                // issue the next read
                if (scan_more)
                begin
                    ram_re       = 1'b1;
                    ram_raddr    = scan_reg[IW-1:0];
                    rd_idx_next  = scan_reg[IW-1:0];
                    scan_next    = scan_reg + CW'(1);
                    rd_pend_next = 1'b1;
                end
                else
                begin
                    rd_pend_next = 1'b0;
                end

                // shared comparator, ties go to the later id
                if (rd_pend_reg && !rd_dead && (!found_reg || rd_prio >= best_prio_reg))
                begin
                    found_next     = 1'b1;
                    best_idx_next  = rd_idx_reg;
                    best_prio_next = rd_prio;
                    best_pay_next  = rd_pay;
                end

                if (scan_end)
                begin
                    if (found_reg)
                    begin
                        res_next.result_id    = 8'(best_idx_reg);
                        res_next.payload_out  = best_pay_w[31:0];
                        res_next.priority_out = best_prio_w[15:0];
                    end
                    else
                    begin
                        res_next.status = STATUS_EMPTY;
                    end
                end
            end
            ST_RETIRE:
            begin
                ram_we    = 1'b1;
                ram_waddr = best_idx_reg;
                ram_wdata = {1'b1, best_prio_reg, best_pay_reg};
            end
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issued_reg    <= '0;
            scan_reg      <= '0;
            rd_pend_reg   <= 1'b0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issued_reg    <= issued_next;
            scan_reg      <= scan_next;
            rd_pend_reg   <= rd_pend_next;
            found_reg     <= found_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        id_reg        <= id_next;
        pay_reg       <= pay_next;
        rd_idx_reg    <= rd_idx_next;
        best_idx_reg  <= best_idx_next;
        best_prio_reg <= best_prio_next;
        best_pay_reg  <= best_pay_next;
        res_reg       <= res_next;
        rsp_reg       <= rsp_next;
    end

    // one command transaction at a time
    assign cmd_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef NO_ASSERTIONS
    // issued count never runs past the table
    a_issued_bound: assert property (@(posedge clk) disable iff (!rst_n)
        issued_reg <= CW'(CAPACITY))
        else $error("issued count beyond capacity");

    // issued count moves only on a dispatched add, and by one
    a_issued_step: assert property (@(posedge clk) disable iff (!rst_n)
        issued_reg != $past(issued_reg) |->
            $past(state_reg == ST_DISPATCH && kind_reg == KIND_ADD) &&
            issued_reg == $past(issued_reg) + CW'(1))
        else $error("issued count changed outside add");

    // a retire write only follows a pop scan that found an entry
    a_retire_found: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RETIRE |-> found_reg && kind_reg == KIND_POP)
        else $error("retire without a found entry");

    // a response transaction is only raised from the done state
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("response raised outside done state");
`endif

endmodule
